// ===== rtl/totp_hmac_sha1_code_defines.svh =====
// Assertion macros used by the checker file.
`ifndef TOTP_HMAC_SHA1_CODE_DEFINES_SVH
`define TOTP_HMAC_SHA1_CODE_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define TOTP_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("totp check failed");

// Assert that a condition implies a consequence in the next cycle.
`define TOTP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("totp check failed");

`endif

// ===== rtl/totp_pkg.sv =====
package totp_pkg;

  localparam int unsigned KeyWords  = 8;
  localparam int unsigned KeyIdxW   = 3;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned SecW      = 63;
  localparam int unsigned CodeW     = 20;
  localparam logic [5:0]  StepSecs  = 6'd30;
  localparam logic [19:0] Modulus   = 20'd1000000;
  localparam logic [7:0]  IpadByte  = 8'h36;
  localparam logic [7:0]  OpadByte  = 8'h5c;

  // ceil(2^29 / 30): exact quotient for any 21-bit partial dividend below 30 * 2^16.
  localparam logic [24:0] DivRecip  = 25'd17895698;
  // ceil(2^51 / 1000000): exact quotient for any 31-bit value.
  localparam logic [31:0] ModRecip  = 32'd2251799814;

  localparam logic [159:0] ShaInit =
    160'h67452301_efcdab89_98badcfe_10325476_c3d2e1f0;

  typedef struct packed {
    logic start;
    logic init;
  } sha_ctl_t;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) begin
      k = 32'h5a827999;
    end else if (r < 7'd40) begin
      k = 32'h6ed9eba1;
    end else if (r < 7'd60) begin
      k = 32'h8f1bbcdc;
    end else begin
      k = 32'hca62c1d6;
    end
    return k;
  endfunction

endpackage

// ===== rtl/totp_sha1_core.sv =====
module totp_sha1_core import totp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  sha_ctl_t     ctl,
  input  logic [511:0] block,
  output logic         done,
  output logic [159:0] digest
);

  logic [511:0] w_r, w_nxt;
  logic [159:0] h_r, h_nxt;
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [31:0]  a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [6:0]   rnd_r, rnd_nxt;
  logic         run_r, run_nxt;
  logic         done_r, done_nxt;
  logic [31:0]  f, t, wnew;
  logic [159:0] h_base;

  assign h_base = ctl.init ? ShaInit : h_r;

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);
    end else if (rnd_r < 7'd40 || rnd_r >= 7'd60) begin
      f = b_r ^ c_r ^ d_r;
    end else begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
    end
    t = {a_r[26:0], a_r[31:27]} + f + e_r + round_k(rnd_r) + w_r[511:480];
    wnew = w_r[511-13*32 -: 32] ^ w_r[511-8*32 -: 32] ^ w_r[511-2*32 -: 32]
         ^ w_r[511:480];
    wnew = {wnew[30:0], wnew[31]};
  end

  always_comb begin
    w_nxt = w_r; h_nxt = h_r; rnd_nxt = rnd_r; run_nxt = run_r; done_nxt = 1'b0;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r; e_nxt = e_r;
    if (ctl.start) begin
      w_nxt = block; h_nxt = h_base; rnd_nxt = '0; run_nxt = 1'b1;
      a_nxt = h_base[159:128]; b_nxt = h_base[127:96]; c_nxt = h_base[95:64];
      d_nxt = h_base[63:32];   e_nxt = h_base[31:0];
    end else if (run_r) begin
      a_nxt = t; b_nxt = a_r; c_nxt = {b_r[1:0], b_r[31:2]}; d_nxt = c_r; e_nxt = d_r;
      w_nxt = {w_r[479:0], wnew};
      rnd_nxt = rnd_r + 7'd1;
      if (rnd_r == 7'd79) begin
        run_nxt = 1'b0;
        done_nxt = 1'b1;
        h_nxt = {h_r[159:128] + t, h_r[127:96] + a_r,
                 h_r[95:64] + {b_r[1:0], b_r[31:2]}, h_r[63:32] + c_r, h_r[31:0] + d_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r <= '0;
    end else begin
      run_r <= run_nxt;
      done_r <= done_nxt;
      rnd_r <= rnd_nxt;
    end
    w_r <= w_nxt; h_r <= h_nxt;
    a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt; e_r <= e_nxt;
  end

  assign done = done_r;
  assign digest = h_r;

endmodule

// ===== rtl/totp_hmac_sha1_code.sv =====
// Six-digit TOTP generator built on HMAC-SHA1.
//
// Software loads the raw key through the configuration port: cfg_we with
// cfg_index 0 to 7 writes one 64-bit big-endian key word; other indexes are
// ignored. Write the key only while busy is low.
// A transfer on the input channel happens when start is high and busy is low;
// in_unix_seconds is then captured and busy rises on the next cycle.
// The time is divided by 30 one 16-bit digit per cycle, with a reciprocal
// multiplication on the shared 32 by 32 multiplier. Four SHA-1 compressions
// follow on one shared round unit, each a launch, 80 rounds and a step that
// takes the digest. Truncation and the reduction by one million on the same
// multiplier (quotient estimate, then remainder) come next, then an output
// state. The result appears on out_otp_code, qualified by out_valid.
// The receiver cannot stall, and busy is already low in the out_valid cycle,
// so a new start may follow at once; a new time is taken only when the
// previous code is out.
// Reset clears the key words to zero and returns the sequencer to idle.
module totp_hmac_sha1_code import totp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [SecW-1:0]    in_unix_seconds,
  output logic               out_valid,
  output logic [CodeW-1:0]   out_otp_code,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_wdata
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_DIV   = 8'b0000_0010,
    ST_SHA   = 8'b0000_0100,
    ST_WAIT  = 8'b0000_1000,
    ST_TRUNC = 8'b0001_0000,
    ST_MOD   = 8'b0010_0000,
    ST_OUT   = 8'b0100_0000,
    ST_SPARE = 8'b1000_0000
  } state_t;

  state_t         state_r, state_nxt;
  logic [63:0]    key_r [KeyWords];
  logic [63:0]    quo_r, quo_nxt;
  logic [4:0]     rem_r, rem_nxt;
  logic [5:0]     cnt_r, cnt_nxt;
  logic [1:0]     blk_r, blk_nxt;
  logic [159:0]   inner_r, inner_nxt;
  logic [11:0]    modq_r, modq_nxt;
  logic [30:0]    bin_r, bin_nxt;
  logic [CodeW-1:0] code_r, code_nxt;
  logic           valid_r, valid_nxt;
  sha_ctl_t       sha_ctl;
  logic [511:0]   sha_block, key_blk;
  logic           sha_done;
  logic [159:0]   sha_digest;
  logic [3:0]     off;
  logic [31:0]    word;
  logic [31:0]    mul_a, mul_b;
  logic [63:0]    mul_p;
  logic [20:0]    div_v, div_back, div_diff;
  logic [15:0]    div_q;
  logic [30:0]    mod_diff;

  always_comb begin
    for (int i = 0; i < KeyWords; i++) begin
      for (int j = 0; j < 8; j++) begin
        key_blk[511 - 64*i - 8*j -: 8] = key_r[i][63 - 8*j -: 8]
          ^ ((blk_r[1] == 1'b0) ? IpadByte : OpadByte);
      end
    end
  end

  // Block order: inner key block, inner message block, outer key block,
  // outer digest block.
  always_comb begin
    unique case (blk_r)
      2'd1: sha_block = {quo_r, 8'h80, 376'd0, 64'd576};
      2'd3: sha_block = {inner_r, 8'h80, 280'd0, 64'd672};
      default: sha_block = key_blk;
    endcase
  end

  // The 32 by 32 multiplier is shared by the division and the reduction steps.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_DIV: begin
        mul_a = {11'd0, div_v};
        mul_b = {7'd0, DivRecip};
      end
      ST_MOD: begin
        if (cnt_r[0] == 1'b0) begin
          mul_a = {1'b0, bin_r};
          mul_b = ModRecip;
        end else begin
          mul_a = {20'd0, modq_r};
          mul_b = {12'd0, Modulus};
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // One 16-bit digit of the division by 30: the running remainder on top.
  assign div_v    = {rem_r, quo_r[63:48]};
  assign div_q    = mul_p[44:29];
  assign div_back = {5'd0, div_q} * {15'd0, StepSecs};
  assign div_diff = div_v - div_back;

  assign mod_diff = bin_r - mul_p[30:0];

  always_comb begin
    off = sha_digest[3:0];
    word = sha_digest[159 - 8*off -: 32];
  end

  always_comb begin
    state_nxt = state_r; quo_nxt = quo_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    blk_nxt = blk_r; inner_nxt = inner_r; modq_nxt = modq_r; bin_nxt = bin_r;
    code_nxt = code_r; valid_nxt = 1'b0; sha_ctl = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          quo_nxt = {1'b0, in_unix_seconds}; rem_nxt = '0; cnt_nxt = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // Shift the next digit out of the top and the quotient digit in below.
        quo_nxt = {quo_r[47:0], div_q};
        rem_nxt = div_diff[4:0];
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd3) begin
          blk_nxt = 2'd0;
          state_nxt = ST_SHA;
        end
      end
      ST_SHA: begin
        sha_ctl.start = 1'b1;
        sha_ctl.init = (blk_r == 2'd0) || (blk_r == 2'd2);
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (sha_done) begin
          if (blk_r == 2'd1) begin
            inner_nxt = sha_digest;
          end
          blk_nxt = blk_r + 2'd1;
          state_nxt = (blk_r == 2'd3) ? ST_TRUNC : ST_SHA;
        end
      end
      ST_TRUNC: begin
        bin_nxt = word[30:0];
        cnt_nxt = '0;
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        // First the quotient by one million, then the remainder.
        if (cnt_r[0] == 1'b0) begin
          modq_nxt = mul_p[62:51];
          cnt_nxt = cnt_r + 6'd1;
        end else begin
          code_nxt = mod_diff[CodeW-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
      for (int i = 0; i < KeyWords; i++) begin
        key_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      if (cfg_we && cfg_index < CfgIdxW'(KeyWords)) begin
        key_r[cfg_index[KeyIdxW-1:0]] <= cfg_wdata;
      end
    end
    quo_r <= quo_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt; blk_r <= blk_nxt;
    inner_r <= inner_nxt; modq_r <= modq_nxt; bin_r <= bin_nxt; code_r <= code_nxt;
  end

  totp_sha1_core u_sha (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (sha_ctl),
    .block  (sha_block),
    .done   (sha_done),
    .digest (sha_digest)
  );

  assign busy = (state_r != ST_IDLE);
  assign out_valid = valid_r;
  assign out_otp_code = code_r;

endmodule

// ===== rtl/totp_checker.sv =====
`include "totp_hmac_sha1_code_defines.svh"
module totp_checker import totp_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [CodeW-1:0] out_otp_code
);

  `TOTP_ASSERT_SAME(a_code_range, clk, rst_n, out_valid, out_otp_code < Modulus)
  `TOTP_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `TOTP_ASSERT_SAME(a_valid_idle, clk, rst_n, out_valid, !busy)
  `TOTP_ASSERT_NEXT(a_valid_pulse, clk, rst_n, out_valid, !out_valid)

endmodule

bind totp_hmac_sha1_code totp_checker u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_otp_code (out_otp_code)
);
